// ===== src/rotary_position_embedding_macros.svh =====
// ----------------------------------------------------------------------------
// Rotary position embedding assertion macros
// Concurrent assertion shorthands. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ROTARY_POSITION_EMBEDDING_MACROS_SVH
`define ROTARY_POSITION_EMBEDDING_MACROS_SVH

// The consequent must hold in the same cycle as the condition.
`define ROPE_ASSERT_IMPLY(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// The consequent must hold in the cycle after the condition.
`define ROPE_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== src/rope_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary position embedding package
// Widths, codes, item types and the arctangent table shared by the block.
// ----------------------------------------------------------------------------
package rope_pkg;

  localparam int HALF_DIM_MAX_DEF = 64;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 4;

  localparam int VAL_W    = 16;
  localparam int POS_W    = 16;
  localparam int FREQ_W   = 32;
  localparam int IDX_IN_W = 6;
  localparam int LIMIT_W  = 17;
  localparam int STATUS_W = 2;
  localparam int PHASE_W  = 32;

  // Datapath widths: rotation coordinates, residual angle, gain product.
  localparam int XW     = 36;
  localparam int ZW     = 34;
  localparam int PROD_W = 68;

  localparam int FRAC_SHIFT  = 16;
  localparam int ROUND_SHIFT = 46;

  // Inverse CORDIC gain in unsigned Q1.30.
  localparam logic [30:0] GAIN_INV_Q30 = 31'd652032874;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd8192;

  localparam logic OP_ROTATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ROTATED = 2'd0,
    ST_PASSED  = 2'd1,
    ST_LOADED  = 2'd2
  } rope_status_t;

  typedef struct packed {
    rope_status_t              status;
    logic [POS_W-1:0]          position;
    logic signed [VAL_W-1:0]   first_value;
    logic signed [VAL_W-1:0]   second_value;
    logic                      last_pair;
  } rope_item_t;

  typedef struct packed {
    rope_item_t        item;
    logic [FREQ_W-1:0] freq;
  } rope_job_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [PHASE_W-1:0] atan_turns(input int step);
    logic [PHASE_W-1:0] a;
    unique case (step)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051D;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2E;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2F9;
      15:      a = 32'h0000_517C;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A2F;
      19:      a = 32'h0000_0517;
      20:      a = 32'h0000_028B;
      21:      a = 32'h0000_0145;
      22:      a = 32'h0000_00A2;
      23:      a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/rope_in_if.sv =====
// ----------------------------------------------------------------------------
// Rotary position embedding input channel
// Valid/ready channel carrying one rotate or load item.
// ----------------------------------------------------------------------------
interface rope_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [rope_pkg::IDX_IN_W-1:0]       freq_index;
  logic [rope_pkg::POS_W-1:0]          position;
  logic signed [rope_pkg::VAL_W-1:0]   first_value;
  logic signed [rope_pkg::VAL_W-1:0]   second_value;
  logic [rope_pkg::FREQ_W-1:0]         frequency_word;
  logic                                last_pair;

  modport source (
    output valid, operation, freq_index, position, first_value, second_value,
           frequency_word, last_pair,
    input  ready
  );

  modport sink (
    input  valid, operation, freq_index, position, first_value, second_value,
           frequency_word, last_pair,
    output ready
  );
endinterface

// ===== src/rope_out_if.sv =====
// ----------------------------------------------------------------------------
// Rotary position embedding result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface rope_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rope_pkg::VAL_W-1:0]   first_result;
  logic signed [rope_pkg::VAL_W-1:0]   second_result;
  logic [rope_pkg::STATUS_W-1:0]       status;
  logic                                last_pair_out;

  modport source (
    output valid, first_result, second_result, status, last_pair_out,
    input  ready
  );

  modport sink (
    input  valid, first_result, second_result, status, last_pair_out,
    output ready
  );
endinterface

// ===== src/rope_front.sv =====
// ----------------------------------------------------------------------------
// Rotary position embedding front end
// Accepts items, owns the frequency table and the position limit, and
// classifies each item before handing it to the queue.
// ----------------------------------------------------------------------------
module rope_front #(
  parameter int HALF_DIM_MAX = rope_pkg::HALF_DIM_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rope_pkg::LIMIT_W-1:0]   cfg_wdata,
  rope_in_if.sink                        in_ch,
  output logic                           push_valid,
  input  logic                           push_ready,
  output rope_pkg::rope_job_t            push_data
);
  import rope_pkg::*;

  localparam int IDX_W = (HALF_DIM_MAX > 1) ? $clog2(HALF_DIM_MAX) : 1;

  logic [FREQ_W-1:0]  freq_mem [HALF_DIM_MAX];
  logic [FREQ_W-1:0]  rd_data_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [IDX_W-1:0]   idx;
  logic               accept;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  rope_item_t         s1_r;
  rope_item_t         s1_nxt;

  assign in_ch.ready = !s1_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // The index wraps modulo the table depth; the fold is a small constant table.
  always_comb begin
    idx = '0;
    for (int k = 0; k < (1 << IDX_IN_W); k++) begin
      if (in_ch.freq_index == IDX_IN_W'(k)) begin
        idx = IDX_W'(k % HALF_DIM_MAX);
      end
    end
  end

  always_comb begin
    s1_nxt.position     = in_ch.position;
    s1_nxt.first_value  = in_ch.first_value;
    s1_nxt.second_value = in_ch.second_value;
    s1_nxt.last_pair    = in_ch.last_pair;
    priority if (in_ch.operation == OP_LOAD) begin
      s1_nxt.status = ST_LOADED;
    end else if ({1'b0, in_ch.position} >= limit_r) begin
      s1_nxt.status = ST_PASSED;
    end else begin
      s1_nxt.status = ST_ROTATED;
    end
  end

  assign s1_valid_nxt = accept || (s1_valid_r && !push_ready);

  // Table write and registered read share the acceptance edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_ch.operation == OP_LOAD) begin
        freq_mem[idx] <= in_ch.frequency_word;
      end
      rd_data_r <= freq_mem[idx];
      s1_r      <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      limit_r    <= LIMIT_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  assign push_valid     = s1_valid_r;
  assign push_data.item = s1_r;
  assign push_data.freq = rd_data_r;

endmodule

// ===== src/rope_fifo.sv =====
// ----------------------------------------------------------------------------
// Rotary position embedding queue
// Short first-in first-out queue between front end and rotation pipeline.
// ----------------------------------------------------------------------------
module rope_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  rope_pkg::rope_job_t  push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output rope_pkg::rope_job_t  pop_data
);
  import rope_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rope_job_t        entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== src/rope_back.sv =====
// ----------------------------------------------------------------------------
// Rotary position embedding rotation pipeline
// Phase multiply, quadrant fold, CORDIC stages, gain correction, rounding
// and saturation, with the output register at the end.
// ----------------------------------------------------------------------------
module rope_back #(
  parameter int CORDIC_STEPS = rope_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  rope_pkg::rope_job_t  pop_data,
  rope_out_if.source           out_ch
);
  import rope_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI     = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO     = PROD_W'(-32768);

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    priority if (v > SAT_HI) begin
      r = 16'sh7FFF;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  logic adv;

  // Phase stage.
  logic [PHASE_W-1:0]      ph_prod;
  logic                    ph_valid_r;
  logic [PHASE_W-1:0]      ph_r;
  rope_item_t              ph_item_r;

  // Quadrant fold into the first CORDIC slot, then one slot per step.
  logic                    flip;
  logic [PHASE_W-1:0]      phase_adj;
  logic signed [XW-1:0]    x_in;
  logic signed [XW-1:0]    y_in;
  logic [NSTEPS:0]         cv_r;
  logic signed [XW-1:0]    cx_r [NSTEPS+1];
  logic signed [XW-1:0]    cy_r [NSTEPS+1];
  logic signed [ZW-1:0]    cz_r [NSTEPS+1];
  rope_item_t              citem_r [NSTEPS+1];

  // Gain stage.
  logic                    g_valid_r;
  logic signed [PROD_W-1:0] px_nxt;
  logic signed [PROD_W-1:0] py_nxt;
  logic signed [PROD_W-1:0] px_r;
  logic signed [PROD_W-1:0] py_r;
  rope_item_t              g_item_r;

  // Output stage.
  logic signed [PROD_W-1:0] rx;
  logic signed [PROD_W-1:0] ry;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] first_nxt;
  logic signed [VAL_W-1:0] second_nxt;
  logic signed [VAL_W-1:0] first_r;
  logic signed [VAL_W-1:0] second_r;
  rope_status_t            status_r;
  logic                    last_r;

  assign adv       = !out_valid_r || out_ch.ready;
  assign pop_ready = adv;

  // Only the low bits of position times frequency form the phase, so the
  // product is kept to the phase width.
  assign ph_prod = {{(PHASE_W-POS_W){1'b0}}, pop_data.item.position} * pop_data.freq;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r      <= ph_prod;
      ph_item_r <= pop_data.item;
    end
  end

  // Quadrants one and two are folded by a half turn and a negation.
  always_comb begin
    flip      = (ph_r[PHASE_W-1:PHASE_W-2] == 2'b01) || (ph_r[PHASE_W-1:PHASE_W-2] == 2'b10);
    phase_adj = flip ? (ph_r + 32'h8000_0000) : ph_r;
    x_in      = {{(XW-VAL_W-FRAC_SHIFT){ph_item_r.first_value[VAL_W-1]}},
                 ph_item_r.first_value, {FRAC_SHIFT{1'b0}}};
    y_in      = {{(XW-VAL_W-FRAC_SHIFT){ph_item_r.second_value[VAL_W-1]}},
                 ph_item_r.second_value, {FRAC_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0]    <= flip ? -x_in : x_in;
      cy_r[0]    <= flip ? -y_in : y_in;
      cz_r[0]    <= {{(ZW-PHASE_W){phase_adj[PHASE_W-1]}}, phase_adj};
      citem_r[0] <= ph_item_r;
    end
  end

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_turns(i));
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign xs = cx_r[i] >>> i;
    assign ys = cy_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz_r[i][ZW-1]) begin
          cx_r[i+1] <= cx_r[i] - ys;
          cy_r[i+1] <= cy_r[i] + xs;
          cz_r[i+1] <= cz_r[i] - ANG;
        end else begin
          cx_r[i+1] <= cx_r[i] + ys;
          cy_r[i+1] <= cy_r[i] - xs;
          cz_r[i+1] <= cz_r[i] + ANG;
        end
        citem_r[i+1] <= citem_r[i];
      end
    end
  end

  always_comb begin
    px_nxt = $signed({{(PROD_W-XW){cx_r[NSTEPS][XW-1]}}, cx_r[NSTEPS]}) *
             $signed({{(PROD_W-31){1'b0}}, GAIN_INV_Q30});
    py_nxt = $signed({{(PROD_W-XW){cy_r[NSTEPS][XW-1]}}, cy_r[NSTEPS]}) *
             $signed({{(PROD_W-31){1'b0}}, GAIN_INV_Q30});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      g_item_r <= citem_r[NSTEPS];
    end
  end

  // Round to nearest with halves upwards, then saturate; passed pairs keep their values and loads give zeros.
  always_comb begin
    rx = (px_r + ROUND_BIAS) >>> ROUND_SHIFT;
    ry = (py_r + ROUND_BIAS) >>> ROUND_SHIFT;
    unique case (g_item_r.status)
      ST_ROTATED: begin
        first_nxt  = sat16(rx);
        second_nxt = sat16(ry);
      end
      ST_PASSED: begin
        first_nxt  = g_item_r.first_value;
        second_nxt = g_item_r.second_value;
      end
      default: begin
        first_nxt  = '0;
        second_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      status_r <= g_item_r.status;
      last_r   <= g_item_r.last_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_valid_r  <= 1'b0;
      cv_r        <= '0;
      g_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ph_valid_r  <= pop_valid;
      cv_r        <= {cv_r[NSTEPS-1:0], ph_valid_r};
      g_valid_r   <= cv_r[NSTEPS];
      out_valid_r <= g_valid_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.first_result  = first_r;
  assign out_ch.second_result = second_r;
  assign out_ch.status        = status_r;
  assign out_ch.last_pair_out = last_r;

endmodule

// ===== src/rotary_position_embedding.sv =====
// An item passes the front stage register, the queue, the phase register, the fold
// register, the CORDIC step registers, the gain register and the output register.
// Throughput: one item per cycle; the rotation pipeline advances one stage a cycle unless the result side stalls.
// Reset: rst_n is synchronous and active low; it empties the pipeline and queue
// and sets position_limit to 8192. The frequency table is not cleared.
// ----------------------------------------------------------------------------
// Rotary position embedding
// Rotates an element pair by position times a per-index inverse frequency,
// or loads one entry of the frequency table; at or beyond the position limit the pair is passed through.
// ----------------------------------------------------------------------------
`include "rotary_position_embedding_macros.svh"

module rotary_position_embedding #(
  parameter int HALF_DIM_MAX = rope_pkg::HALF_DIM_MAX_DEF,
  parameter int CORDIC_STEPS = rope_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rope_pkg::LIMIT_W-1:0]   cfg_wdata,
  rope_in_if.sink                        in_ch,
  rope_out_if.source                     out_ch
);
  import rope_pkg::*;

  // The front end takes an item, writes or reads the frequency table and
  // decides whether the item is a load, a pass-through or a rotation. The
  // table read is registered, and the classified item and its frequency word
  // wait in the front stage register until the queue takes them.
  logic      push_valid;
  logic      push_ready;
  rope_job_t push_data;

  // The queue lets the front end keep taking items until it is full while
  // the rotation pipeline is held by a stalled result side.
  logic      pop_valid;
  logic      pop_ready;
  rope_job_t pop_data;

  rope_front #(
    .HALF_DIM_MAX (HALF_DIM_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rope_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end multiplies position by the frequency word to get the phase,
  // folds it into the right half-plane, runs one CORDIC step per stage,
  // applies the fixed gain correction, rounds and saturates. The whole
  // pipeline advances together whenever the output register can move.
  rope_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

  // An accepted item is always held in the front stage in the next cycle.
  `ROPE_ASSERT_NEXT(a_accept_to_front, in_ch.valid && in_ch.ready, push_valid, "accepted item lost before the queue")

  // The front end refuses items only while it holds one the queue cannot take.
  `ROPE_ASSERT_IMPLY(a_ready_only_when_blocked, !in_ch.ready, push_valid && !push_ready, "input refused without a blocked front stage")

  // A load result carries zero values.
  `ROPE_ASSERT_IMPLY(a_load_result_zero, out_ch.valid && (out_ch.status == ST_LOADED), (out_ch.first_result == '0) && (out_ch.second_result == '0), "load result with non-zero values")

endmodule

// ===== dv/tb_rotary_position_embedding.sv =====
// ----------------------------------------------------------------------------
// Rotary position embedding testbench
// Drives rotate and load items into the block and keeps a bit-exact copy of
// its arithmetic: frequency table, position limit, quadrant fold, CORDIC with
// gain correction, rounding and clipping. Every result item is checked
// against the oldest outstanding prediction, while both sides of the stream
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rotary_position_embedding;
  timeunit 1ns;
  timeprecision 1ps;

  import rope_pkg::*;

  // Slowest legal run is well under a tenth of this.
  localparam int CYCLE_LIMIT  = 500_000;
  // Cycles allowed for stray results once nothing is outstanding.
  localparam int DRAIN_CYCLES = CORDIC_STEPS_DEF + 12;
  localparam int REPORT_MAX   = 10;

  // Arctangent of 2^-i in units of 2^-32 of a turn.
  localparam longint TURN_ANGLE [ATAN_ENTRIES] = '{
    'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
    'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051
  };

  // One item as offered on the input channel.
  typedef struct {
    logic                    operation;
    logic [IDX_IN_W-1:0]     index;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] v0;
    logic signed [VAL_W-1:0] v1;
    logic [FREQ_W-1:0]       freq;
    logic                    last;
  } pair_req_t;

  // One item as it should appear on the result channel.
  typedef struct {
    logic signed [VAL_W-1:0] first;
    logic signed [VAL_W-1:0] second;
    rope_status_t            status;
    logic                    last;
  } pair_res_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [LIMIT_W-1:0]  cfg_wdata;

  rope_in_if  in_ch ();
  rope_out_if out_ch ();

  rotary_position_embedding DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Our own view of the block's state, updated as each item is accepted.
  logic [FREQ_W-1:0]  freq_entries [HALF_DIM_MAX_DEF];
  bit                 entry_loaded [HALF_DIM_MAX_DEF];
  logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;

  // Results predicted but not yet seen, oldest first.
  pair_res_t pending_results [$];

  int  fail_count = 0;
  // Idle bursts on the sending and the receiving side.
  bit  send_gaps  = 1'b0;
  bit  take_gaps  = 1'b0;
  // A request for a long stall of the receiver, in cycles.
  int  hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, should the block hang.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Gain correction, rounding to nearest with halves upwards, then clipping to
  // signed Q1.15.
  function automatic logic signed [VAL_W-1:0] scale_and_clip(input longint acc);
    longint r;
    r = (acc * longint'(GAIN_INV_Q30) + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return VAL_W'(r);
  endfunction

  // Works out the result of one accepted item and applies any table write.
  function automatic pair_res_t compute_rope_result(input pair_req_t r);
    pair_res_t          res;
    longint             x;
    longint             y;
    longint             z;
    longint             xs;
    longint             ys;
    logic [63:0]        product;
    logic [PHASE_W-1:0] phase;
    res.last = r.last;
    if (r.operation == OP_LOAD) begin
      freq_entries[r.index] = r.freq;
      entry_loaded[r.index] = 1'b1;
      res.first  = '0;
      res.second = '0;
      res.status = ST_LOADED;
    end else if ({1'b0, r.position} >= limit_shadow) begin
      // At or beyond the limit the pair goes through untouched.
      res.first  = r.v0;
      res.second = r.v1;
      res.status = ST_PASSED;
    end else begin
      product = 64'(r.position) * 64'(freq_entries[r.index]);
      phase   = product[PHASE_W-1:0];
      x = longint'(r.v0) <<< FRAC_SHIFT;
      y = longint'(r.v1) <<< FRAC_SHIFT;
      // Second and third quadrants are folded by half a turn and a negation.
      if (phase[PHASE_W-1] != phase[PHASE_W-2]) begin
        x = -x;
        y = -y;
        phase = phase + 32'h8000_0000;
      end
      z = phase[PHASE_W-1] ? longint'(phase) - 64'sd4294967296 : longint'(phase);
      for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_ENTRIES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - TURN_ANGLE[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + TURN_ANGLE[i];
        end
      end
      res.first  = scale_and_clip(x);
      res.second = scale_and_clip(y);
      res.status = ST_ROTATED;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: ready generation and checking
  // --------------------------------------------------------------------------

  // Ready is decided once per cycle, so it never gets two assignments in one
  // step. A long hold request takes priority over the short random bursts.
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_request > 0) begin
        stall_left = hold_request - 1;
        hold_request = 0;
        out_ch.ready <= 1'b0;
      end else if (take_gaps && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("[%0t] %s", $time, msg);
  endfunction

  // Each result item taken is compared field by field with the oldest
  // prediction.
  always @(posedge clk) begin : check_results
    pair_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        log_failure($sformatf("unexpected result: first %0d second %0d status %0d last %0b",
                              out_ch.first_result, out_ch.second_result,
                              out_ch.status, out_ch.last_pair_out));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.first_result !== want.first || out_ch.second_result !== want.second ||
            out_ch.status !== want.status || out_ch.last_pair_out !== want.last) begin
          log_failure($sformatf(
            "mismatch: expected first %0d second %0d status %0d last %0b, got %0d %0d %0d %0b",
            want.first, want.second, want.status, want.last,
            out_ch.first_result, out_ch.second_result, out_ch.status,
            out_ch.last_pair_out));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one item and returns in the step of its acceptance. Valid stays
  // high afterwards unless an idle burst or a drain lowers it.
  task automatic send_item(input pair_req_t r);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= r.operation;
    in_ch.freq_index     <= r.index;
    in_ch.position       <= r.position;
    in_ch.first_value    <= r.v0;
    in_ch.second_value   <= r.v1;
    in_ch.frequency_word <= r.freq;
    in_ch.last_pair      <= r.last;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(compute_rope_result(r));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The limit is only changed once the block has emptied.
  task automatic write_position_limit(input logic [LIMIT_W-1:0] value);
    wait_for_results();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_shadow = value;
  endtask

  function automatic pair_req_t make_rotate(input logic [IDX_IN_W-1:0] index,
                                            input logic [POS_W-1:0] position,
                                            input logic signed [VAL_W-1:0] v0,
                                            input logic signed [VAL_W-1:0] v1,
                                            input logic last);
    pair_req_t r;
    r.operation = OP_ROTATE;
    r.index     = index;
    r.position  = position;
    r.v0        = v0;
    r.v1        = v1;
    r.freq      = $urandom;   // ignored by a rotate
    r.last      = last;
    return r;
  endfunction

  function automatic pair_req_t make_load(input logic [IDX_IN_W-1:0] index,
                                          input logic [FREQ_W-1:0] freq,
                                          input logic last);
    pair_req_t r;
    r = make_rotate(index, POS_W'($urandom), VAL_W'($urandom), VAL_W'($urandom), last);
    r.operation = OP_LOAD;
    r.freq      = freq;
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Positions cluster around the limit and below it, where the rotation is
  // exercised, with a share spread over the whole range.
  function automatic logic [POS_W-1:0] pick_position();
    longint p;
    longint top;
    top = (limit_shadow > 65536) ? 65536 : longint'(limit_shadow);
    case ($urandom_range(0, 3))
      0: p = $urandom_range(0, 65535);
      1: p = longint'(limit_shadow) + $urandom_range(0, 3) - 2;
      default: p = (top == 0) ? $urandom_range(0, 65535) : $urandom_range(0, top - 1);
    endcase
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return POS_W'(p);
  endfunction

  // Real inverse frequencies are mostly small fractions of a turn.
  function automatic logic [FREQ_W-1:0] pick_frequency();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFF_FFFF;
      1:       return $urandom >> $urandom_range(0, 31);
      2, 3:    return $urandom >> $urandom_range(8, 24);
      default: return $urandom;
    endcase
  endfunction

  // A rotate only ever reads an entry that has been loaded since reset.
  function automatic pair_req_t random_item(input int load_pct);
    logic [IDX_IN_W-1:0] index;
    if ($urandom_range(1, 100) <= load_pct)
      return make_load(IDX_IN_W'($urandom), pick_frequency(), 1'($urandom));
    do index = IDX_IN_W'($urandom); while (!entry_loaded[index]);
    return make_rotate(index, pick_position(), pick_value(), pick_value(), 1'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Table loads at the index and frequency extremes, then rotations through
  // each quadrant, clipping, both sides of the reset limit and the largest
  // position.
  task automatic test_directed_cases();
    send_item(make_load(6'd0,  32'h4000_0000, 1'b0));
    send_item(make_load(6'd63, 32'hFFFF_FFFF, 1'b1));
    send_item(make_load(6'd1,  32'h2000_0000, 1'b0));
    send_item(make_load(6'd2,  32'h0000_0000, 1'b1));
    send_item(make_load(6'd42, 32'h8000_0000, 1'b0));
    // Quarter turn per position: phase zero, then one in each later quadrant.
    send_item(make_rotate(6'd0, 16'd0, 16'sd12000, -16'sd7000, 1'b0));
    send_item(make_rotate(6'd0, 16'd1, 16'sd12000, -16'sd7000, 1'b1));
    send_item(make_rotate(6'd0, 16'd2, 16'sd12000, -16'sd7000, 1'b0));
    send_item(make_rotate(6'd0, 16'd3, 16'sd12000, -16'sd7000, 1'b1));
    // An eighth of a turn on full-scale inputs grows past the Q1.15 range.
    send_item(make_rotate(6'd1, 16'd1, -16'sd32768, -16'sd32768, 1'b0));
    send_item(make_rotate(6'd1, 16'd1, 16'sd32767, 16'sd32767, 1'b1));
    send_item(make_rotate(6'd1, 16'd1, 16'sd32767, -16'sd32768, 1'b0));
    send_item(make_rotate(6'd2, 16'd100, -16'sd32768, 16'sd32767, 1'b1));
    send_item(make_rotate(6'd42, 16'd1, 16'sd5, -16'sd1, 1'b0));
    // Just below, at and far beyond the reset limit.
    send_item(make_rotate(6'd63, 16'd8191, 16'sd32767, -16'sd32768, 1'b1));
    send_item(make_rotate(6'd63, 16'd8192, -16'sd32768, 16'sd32767, 1'b0));
    send_item(make_rotate(6'd63, 16'd65535, 16'sd1234, -16'sd4321, 1'b1));
    send_item(make_rotate(6'd0, 16'd65535, 16'sd0, -16'sd1, 1'b0));
  endtask

  // The limit register at its extremes and a random setting. Zero lets every
  // position pass, the all-ones value lets none pass.
  task automatic test_limit_register();
    logic [LIMIT_W-1:0] settings [5];
    settings = '{17'd1, 17'd65536, 17'd0, 17'h1FFFF, 17'($urandom_range(2, 65535))};
    foreach (settings[s]) begin
      write_position_limit(settings[s]);
      send_item(make_rotate(6'd0, 16'd0, pick_value(), pick_value(), 1'b1));
      send_item(make_rotate(6'd63, 16'd65535, pick_value(), pick_value(), 1'b0));
      repeat (28) send_item(random_item(10));
    end
    write_position_limit(LIMIT_RESET);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the pipeline and its queue fill and the input stalls.
  task automatic test_output_backpressure();
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    hold_request = 120;
    repeat (60) send_item(random_item(10));
    wait_for_results();
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    hold_request = 80;
    repeat (60) send_item(random_item(10));
  endtask

  // The bulk of the run: blocks of mixed items with idling switched on and
  // off per side, and a fresh limit now and then.
  task automatic test_random_traffic();
    for (int blk = 0; blk < 12; blk++) begin
      send_gaps = ($urandom_range(0, 2) != 0);
      take_gaps = ($urandom_range(0, 2) != 0);
      if (blk == 4 || blk == 8)
        write_position_limit(17'($urandom_range(1, 65536)));
      repeat (100) send_item(random_item(15));
    end
    write_position_limit(LIMIT_RESET);
  endtask

  // Back-to-back items with both sides always ready.
  task automatic test_quiet_tail();
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    repeat (150) send_item(random_item(15));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.operation      <= OP_ROTATE;
    in_ch.freq_index     <= '0;
    in_ch.position       <= '0;
    in_ch.first_value    <= '0;
    in_ch.second_value   <= '0;
    in_ch.frequency_word <= '0;
    in_ch.last_pair      <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The opening checks run with idling on both sides.
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    test_directed_cases();
    test_limit_register();
    test_output_backpressure();
    test_random_traffic();
    test_quiet_tail();

    // Let everything outstanding arrive, then watch a little longer for
    // anything extra.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      log_failure($sformatf("%0d results never arrived", pending_results.size()));

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/rope_pkg.sv
src/rope_in_if.sv
src/rope_out_if.sv
src/rope_front.sv
src/rope_fifo.sv
src/rope_back.sv
src/rotary_position_embedding.sv
dv/tb_rotary_position_embedding.sv
